>>> design/swm_pkg.sv
// shared types and constants for the sliding window maximum block
`timescale 1ns / 1ps

package swm_pkg;

  localparam int unsigned WinW = 7;
  localparam int unsigned MaxW = 32;
  localparam logic [WinW-1:0] WinReset = 7'd4;

  typedef struct packed {
    logic en;
    logic clr;
  } swm_ctl_t;

endpackage

>>> design/swm_in_if.sv
// sample input channel
`timescale 1ns / 1ps

interface swm_in_if #(
  parameter int unsigned SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

>>> design/swm_out_if.sv
// window maximum result channel
`timescale 1ns / 1ps

interface swm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] window_max;
  logic               final_window;

  modport source (output valid, output window_max, output final_window, input ready);
  modport sink (input valid, input window_max, input final_window, output ready);
endinterface

>>> design/swm_cfg_if.sv
// window size configuration write channel
`timescale 1ns / 1ps

interface swm_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] window_size;

  modport source (output valid, output window_size, input ready);
  modport sink (input valid, input window_size, output ready);
endinterface

>>> design/swm_cell.sv
// one candidate cell of the shift chain
`timescale 1ns / 1ps

module swm_cell #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swm_pkg::swm_ctl_t             ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] up_value_i,
  input  logic                          up_live_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          age_ok_i,
  output logic signed [SAMPLE_BITS-1:0] value_o,
  output logic                          survive_o
);
  import swm_pkg::*;

  logic signed [SAMPLE_BITS-1:0] value_q;
  logic                          live_q;
  logic                          live_d;

  assign survive_o = live_q && (value_q > sample_i) && age_ok_i;
  assign value_o   = value_q;
  assign live_d    = ctl_i.clr ? 1'b0 : up_live_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else if (ctl_i.en) begin
      live_q <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      value_q <= up_value_i;
    end
  end
endmodule

>>> design/swm_select.sv
// priority select of the oldest live candidate over a mux tree
`timescale 1ns / 1ps

module swm_select #(
  parameter int unsigned N = 64,
  parameter int unsigned W = 32
) (
  input  logic         leaf_valid_i [N],
  input  logic [W-1:0] leaf_data_i  [N],
  output logic         valid_o,
  output logic [W-1:0] data_o
);
  localparam int unsigned P = 2 ** $clog2(N);

  logic         node_v [2*P-1];
  logic [W-1:0] node_d [2*P-1];

  for (genvar g = 0; g < P; g++) begin : g_leaf
    if (g < N) begin : g_used
      assign node_v[P-1+g] = leaf_valid_i[g];
      assign node_d[P-1+g] = leaf_data_i[g];
    end else begin : g_pad
      assign node_v[P-1+g] = 1'b0;
      assign node_d[P-1+g] = '0;
    end
  end

  // older entries sit in the right subtree and win
  for (genvar n = 0; n < P - 1; n++) begin : g_node
    assign node_v[n] = node_v[2*n+2] | node_v[2*n+1];
    assign node_d[n] = node_v[2*n+2] ? node_d[2*n+2] : node_d[2*n+1];
  end

  assign valid_o = node_v[0];
  assign data_o  = node_d[0];
endmodule

>>> design/sliding_window_maximum.sv
// sliding_window_maximum: top level with cell chain, result register and window register
// output: a result sits in the output register in the cycle after its sample transaction
// throughput: one sample per cycle; the output register stalls input only when held
// the cell chain compares every candidate against the new sample in the same cycle
// reset: all candidates dead, sample count and fill flag clear, window size 4
`timescale 1ns / 1ps

module sliding_window_maximum #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  swm_in_if.sink    in_i,
  swm_out_if.source out_o,
  swm_cfg_if.sink   cfg_i
);
  import swm_pkg::*;

  logic [WinW-1:0] win_q;
  logic [WinW-1:0] win_d;
  logic [WinW-1:0] k_eff;
  logic [WinW-1:0] seen_q;
  logic [WinW-1:0] seen_d;
  logic            full_q;
  logic            full_d;
  logic            full_now;
  logic            in_fire;
  logic            produce;
  logic            out_valid_q;
  logic            out_valid_d;
  logic [MaxW-1:0] out_max_q;
  logic [MaxW-1:0] out_max_d;
  logic            out_last_q;
  logic            out_last_d;
  swm_ctl_t        ctl;

  logic signed [SAMPLE_BITS-1:0] cell_val  [MAX_WINDOW];
  logic                          cell_srv  [MAX_WINDOW];
  logic                          age_ok    [MAX_WINDOW];
  logic        [SAMPLE_BITS-1:0] leaf_data [MAX_WINDOW];
  logic                          leaf_vld  [MAX_WINDOW];
  logic        [SAMPLE_BITS-1:0] sel_data;
  logic                          sel_vld;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;

  always_comb begin
    if (win_q == '0) begin
      k_eff = WinW'(1);
    end else if ({25'd0, win_q} > 32'(MAX_WINDOW)) begin
      k_eff = WinW'(MAX_WINDOW);
    end else begin
      k_eff = win_q;
    end
  end

  assign ctl.en  = in_fire;
  assign ctl.clr = in_i.last_sample;

  assign leaf_data[0] = in_i.sample;
  assign leaf_vld[0]  = 1'b1;

  for (genvar g = 1; g < MAX_WINDOW; g++) begin : g_leaf
    assign leaf_data[g] = cell_val[g-1];
    assign leaf_vld[g]  = cell_srv[g-1];
  end

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    assign age_ok[g] = 32'(g + 1) < {25'd0, k_eff};

    swm_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .up_value_i (leaf_data[g]),
      .up_live_i  (leaf_vld[g]),
      .sample_i   (in_i.sample),
      .age_ok_i   (age_ok[g]),
      .value_o    (cell_val[g]),
      .survive_o  (cell_srv[g])
    );
  end

  swm_select #(
    .N(MAX_WINDOW),
    .W(SAMPLE_BITS)
  ) u_select (
    .leaf_valid_i (leaf_vld),
    .leaf_data_i  (leaf_data),
    .valid_o      (sel_vld),
    .data_o       (sel_data)
  );

  if (SAMPLE_BITS >= MaxW) begin : g_out_trunc
    assign out_max_d = sel_data[MaxW-1:0];
  end else begin : g_out_ext
    assign out_max_d = {{(MaxW - SAMPLE_BITS){1'b0}}, sel_data};
  end

  assign full_now = full_q || (({1'b0, seen_q} + 8'd1) >= {1'b0, k_eff});
  assign produce  = full_now && sel_vld;

  always_comb begin
    win_d       = win_q;
    seen_d      = seen_q;
    full_d      = full_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    if (cfg_i.valid) begin
      win_d = cfg_i.window_size;
    end
    if (in_fire) begin
      out_valid_d = produce;
      out_last_d  = in_i.last_sample;
      if (in_i.last_sample) begin
        seen_d = '0;
        full_d = 1'b0;
      end else begin
        seen_d = (seen_q != '1) ? seen_q + WinW'(1) : seen_q;
        full_d = full_now;
      end
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= WinReset;
      seen_q      <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      seen_q      <= seen_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_max_q  <= out_max_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.window_max   = out_max_q;
  assign out_o.final_window = out_last_q;
endmodule

>>> tb/swm_window_max_pkg.sv
// reference tracker of window maxima used by the sliding window maximum testbench
`timescale 1ns / 1ps

package swm_window_max_pkg;

  localparam int unsigned DequeDepth = 64;

  typedef logic signed [31:0] sample_t;

  typedef struct packed {
    sample_t window_max;
    logic    final_window;
  } window_result_t;

  class window_max_tracker;
    sample_t                cand_value[DequeDepth];
    logic [15:0]            cand_pos[DequeDepth];
    int unsigned            cand_count;
    logic [15:0]            next_pos;
    bit                     filled;
    logic [swm_pkg::WinW-1:0] win_reg;
    window_result_t         expected_maxima[$];
    int unsigned            errors;

    function new();
      cand_count = 0;
      next_pos   = '0;
      filled     = 1'b0;
      win_reg    = swm_pkg::WinReset;
      errors     = 0;
    endfunction

    function void set_window(logic [swm_pkg::WinW-1:0] size);
      win_reg = size;
    endfunction

    function int unsigned pending();
      return expected_maxima.size();
    endfunction

    function void take_sample(sample_t s, logic last);
      int unsigned    span;
      int unsigned    drop;
      int unsigned    i;
      logic [15:0]    age;
      window_result_t r;
      span = (win_reg == '0) ? 1 : (win_reg > DequeDepth) ? DequeDepth : win_reg;
      // smaller or equal candidates at the back can never win again
      while (cand_count > 0 && s >= cand_value[cand_count-1]) cand_count--;
      drop = 0;
      while (drop < cand_count) begin
        age = next_pos - cand_pos[drop];
        if (age < span) break;
        drop++;
      end
      for (i = 0; i + drop < cand_count; i++) begin
        cand_value[i] = cand_value[i+drop];
        cand_pos[i]   = cand_pos[i+drop];
      end
      cand_count -= drop;
      if (cand_count < DequeDepth) begin
        cand_value[cand_count] = s;
        cand_pos[cand_count]   = next_pos;
        cand_count++;
      end
      if (!filled && next_pos + 1 >= span) filled = 1'b1;
      if (filled) begin
        r.window_max   = cand_value[0];
        r.final_window = last;
        expected_maxima = {expected_maxima, r};
      end
      next_pos++;
      if (last) begin
        cand_count = 0;
        next_pos   = '0;
        filled     = 1'b0;
      end
    endfunction

    function void check_max(window_result_t got);
      window_result_t want;
      if (expected_maxima.size() == 0) begin
        $error("unexpected result: window_max %0d final_window %0b",
               got.window_max, got.final_window);
        errors++;
        return;
      end
      want = expected_maxima[0];
      expected_maxima.delete(0);
      if (got.window_max !== want.window_max) begin
        $error("window_max: expected %0d, actual %0d", want.window_max, got.window_max);
        errors++;
      end
      if (got.final_window !== want.final_window) begin
        $error("final_window: expected %0b, actual %0b",
               want.final_window, got.final_window);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> tb/sliding_window_maximum_test.sv
// top of the sliding window maximum testbench: stimulus, handshakes and result checks
`timescale 1ns / 1ps

module sliding_window_maximum_test;
  import swm_window_max_pkg::*;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned LongSeqLen = 150;

  typedef enum int unsigned {
    StyleRandom,
    StyleNarrow,
    StyleFalling,
    StyleRising,
    StyleExtreme
  } sample_style_e;

  localparam sample_t MinSample = sample_t'(32'h8000_0000);
  localparam sample_t MaxSample = sample_t'(32'h7fff_ffff);

  logic clk_i = 1'b0;
  logic rst_ni;

  swm_in_if #(.SAMPLE_BITS(32)) in_if ();
  swm_out_if                    out_if ();
  swm_cfg_if                    cfg_if ();

  sliding_window_maximum #(
    .MAX_WINDOW (64),
    .SAMPLE_BITS(32)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  window_max_tracker tracker;
  int unsigned       src_idle_pct;
  int unsigned       sink_idle_pct;
  int unsigned       samples_sent;
  int unsigned       stall_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    window_result_t got;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) tracker.set_window(cfg_if.window_size);
      if (in_if.valid && in_if.ready) tracker.take_sample(in_if.sample, in_if.last_sample);
      if (out_if.valid && out_if.ready) begin
        got.window_max   = out_if.window_max;
        got.final_window = out_if.final_window;
        tracker.check_max(got);
      end
      if ((cfg_if.valid && cfg_if.ready) || (in_if.valid && in_if.ready) ||
          (out_if.valid && out_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  task automatic send_sample(input sample_t s, input logic last);
    if ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_if.valid       <= 1'b1;
    in_if.sample      <= s;
    in_if.last_sample <= last;
    do @(posedge clk_i); while (!in_if.ready);
    samples_sent++;
  endtask

  // wait for every expected maximum, then let trailing no-result work finish
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [swm_pkg::WinW-1:0] size);
    settle();
    cfg_if.valid       <= 1'b1;
    cfg_if.window_size <= size;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic int unsigned span_of(logic [swm_pkg::WinW-1:0] size);
    return (size == '0) ? 1 : (size > DequeDepth) ? DequeDepth : size;
  endfunction

  function automatic logic [swm_pkg::WinW-1:0] pick_window();
    int unsigned r;
    r = $urandom_range(19);
    case (r)
      0: return '0;
      1: return '1;
      2: return 7'd64;
      3: return 7'(65 + $urandom_range(62));
      4, 5, 6: return 7'($urandom_range(63, 9));
      default: return 7'($urandom_range(8, 1));
    endcase
  endfunction

  function automatic sample_t make_sample(sample_style_e style, int unsigned idx, sample_t base);
    case (style)
      StyleNarrow:  return sample_t'(int'($urandom_range(8)) - 4);
      StyleFalling: return base - sample_t'(idx * 7);
      StyleRising:  return base + sample_t'(idx * 5);
      StyleExtreme: begin
        case ($urandom_range(4))
          0: return MinSample;
          1: return MaxSample;
          2: return sample_t'(0);
          3: return sample_t'(-1);
          default: return sample_t'(1);
        endcase
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic run_directed();
    // too short for the reset window of four
    send_sample(MinSample, 1'b0);
    send_sample(MaxSample, 1'b0);
    send_sample(sample_t'(-1), 1'b1);
    // ties and both extremes
    send_sample(sample_t'(5), 1'b0);
    send_sample(sample_t'(5), 1'b0);
    send_sample(sample_t'(3), 1'b0);
    send_sample(MinSample, 1'b0);
    send_sample(MaxSample, 1'b0);
    send_sample(sample_t'(0), 1'b1);
    // zero acts as a window of one
    write_window('0);
    send_sample(sample_t'(7), 1'b0);
    send_sample(sample_t'(-7), 1'b1);
    // window grows mid-sequence, expired entries stay gone
    write_window(7'd2);
    send_sample(sample_t'(9), 1'b0);
    send_sample(sample_t'(1), 1'b0);
    send_sample(sample_t'(1), 1'b0);
    write_window(7'd5);
    send_sample(sample_t'(0), 1'b0);
    send_sample(sample_t'(2), 1'b1);
    // oversized window clamps to the deque depth
    write_window('1);
    send_sample(sample_t'(4), 1'b0);
    send_sample(sample_t'(-4), 1'b1);
    write_window(7'd1);
    send_sample(MaxSample, 1'b1);
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned              goal;
    int unsigned              nseq;
    int unsigned              len;
    int unsigned              span;
    int unsigned              j;
    int unsigned              i;
    logic [swm_pkg::WinW-1:0] size;
    sample_style_e            style;
    sample_t                  base;
    bit                       close;
    goal = samples_sent + target;
    while (samples_sent < goal) begin
      size = pick_window();
      write_window(size);
      span = span_of(size);
      nseq = $urandom_range(4, 1);
      for (j = 0; j < nseq; j++) begin
        style = sample_style_e'($urandom_range(4));
        base  = sample_t'($urandom);
        if ($urandom_range(9) == 0) len = $urandom_range(span, 1);
        else len = span + $urandom_range(14);
        if (len > 2) len -= 2;
        // an open sequence carries over into the next window size
        close = (j + 1 < nseq) || ($urandom_range(3) != 0);
        for (i = 0; i < len; i++) begin
          send_sample(make_sample(style, i, base), close && (i + 1 == len));
        end
      end
    end
  endtask

  // one sequence much longer than the widest window
  task automatic run_long();
    int unsigned   i;
    sample_style_e style;
    sample_t       base;
    write_window(7'd64);
    style = StyleRandom;
    base  = '0;
    for (i = 0; i < LongSeqLen; i++) begin
      if (i % 50 == 0) begin
        style = sample_style_e'($urandom_range(4));
        base  = sample_t'($urandom);
      end
      send_sample(make_sample(style, i % 50, base), i + 1 == LongSeqLen);
    end
  endtask

  initial begin
    tracker      = new();
    samples_sent = 0;
    src_idle_pct  = 11;
    sink_idle_pct = 73;
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.sample       <= '0;
    in_if.last_sample  <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.window_size <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(400);
    settle();
    src_idle_pct  = 73;
    sink_idle_pct = 11;
    run_random(400);
    settle();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(250);
    run_long();

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
